/* hdl/gnms_pkg.sv */
package gnms_pkg;

  localparam int MAX_KEPT   = 64;
  localparam int COORD_BITS = 11;

  localparam int POS_W   = COORD_BITS;
  localparam int SIZE_W  = COORD_BITS + 1;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int SUM_W   = SIZE_W + 1;
  localparam int INTER_W = 2 * SUM_W;
  localparam int UNI_W   = INTER_W + 1;
  localparam int RECIP_W = 16;
  localparam int RATIO_W = 8;
  localparam int PROD_W  = INTER_W + RECIP_W;
  localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W   = $clog2(MAX_KEPT + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IOU_RECIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_MIN = 2'd2;

  localparam logic [RECIP_W-1:0] IOU_RECIP_RST  = 16'd10000;
  localparam logic [RATIO_W-1:0] ASPECT_MAX_RST = 8'd5;
  localparam logic [RATIO_W-1:0] ASPECT_MIN_RST = 8'd1;

  localparam logic [1:0] VERDICT_KEPT       = 2'd0;
  localparam logic [1:0] VERDICT_SUPPRESSED = 2'd1;
  localparam logic [1:0] VERDICT_ASPECT     = 2'd2;
  localparam logic [1:0] VERDICT_FULL       = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [AREA_W-1:0] area;
  } gnms_entry_t;

  typedef struct packed {
    logic busy;
    logic hit_vld;
    logic hit;
  } gnms_ovl_stat_t;

endpackage

/* hdl/gnms_if.sv */
interface gnms_box_if;
  import gnms_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  box_x;
  logic [POS_W-1:0]  box_y;
  logic [SIZE_W-1:0] box_w;
  logic [SIZE_W-1:0] box_h;
  logic              frame_start;

  modport source (output valid, box_x, box_y, box_w, box_h, frame_start, input ready);
  modport sink (input valid, box_x, box_y, box_w, box_h, frame_start, output ready);
endinterface

interface gnms_res_if;
  import gnms_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       verdict;
  logic [CNT_W-1:0] kept_total;

  modport source (output valid, verdict, kept_total, input ready);
  modport sink (input valid, verdict, kept_total, output ready);
endinterface

/* hdl/gnms_overlap.sv */
module gnms_overlap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [gnms_pkg::RECIP_W-1:0]    iou_recip,
  input  gnms_pkg::gnms_entry_t           cur_box,
  input  logic                            kept_vld,
  input  gnms_pkg::gnms_entry_t           kept_box,
  output gnms_pkg::gnms_ovl_stat_t        stat
);
  import gnms_pkg::*;

  logic [SUM_W-1:0]        bxe, kxe, bye, kye;
  logic [SUM_W-1:0]        min_xe, max_xs, min_ye, max_ys;
  logic signed [SUM_W:0]   dx, dy;
  logic [SUM_W-1:0]        iw, ih;

  logic                    v1_r, v2_r, v3_r;
  logic [SUM_W-1:0]        iw_r, ih_r;
  logic [AREA_W:0]         asum1_r, asum2_r;
  logic [INTER_W-1:0]      inter2_r, inter3_r;
  logic signed [UNI_W-1:0] uni3_r;
  logic [PROD_W-1:0]       prod3_r;

  // intersection extent, inclusive edges
  assign bxe    = SUM_W'(cur_box.x) + SUM_W'(cur_box.w);
  assign kxe    = SUM_W'(kept_box.x) + SUM_W'(kept_box.w);
  assign bye    = SUM_W'(cur_box.y) + SUM_W'(cur_box.h);
  assign kye    = SUM_W'(kept_box.y) + SUM_W'(kept_box.h);
  assign min_xe = (bxe < kxe) ? bxe : kxe;
  assign min_ye = (bye < kye) ? bye : kye;
  assign max_xs = (cur_box.x > kept_box.x) ? SUM_W'(cur_box.x) : SUM_W'(kept_box.x);
  assign max_ys = (cur_box.y > kept_box.y) ? SUM_W'(cur_box.y) : SUM_W'(kept_box.y);
  assign dx     = $signed({1'b0, min_xe}) - $signed({1'b0, max_xs}) + $signed((SUM_W+1)'(1));
  assign dy     = $signed({1'b0, min_ye}) - $signed({1'b0, max_ys}) + $signed((SUM_W+1)'(1));
  assign iw     = (dx > 0) ? dx[SUM_W-1:0] : '0;
  assign ih     = (dy > 0) ? dy[SUM_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= kept_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    iw_r     <= iw;
    ih_r     <= ih;
    asum1_r  <= (AREA_W+1)'(cur_box.area) + (AREA_W+1)'(kept_box.area);
    inter2_r <= INTER_W'(iw_r) * INTER_W'(ih_r);
    asum2_r  <= asum1_r;
    inter3_r <= inter2_r;
    uni3_r   <= $signed(UNI_W'(asum2_r)) - $signed(UNI_W'(inter2_r));
    prod3_r  <= PROD_W'(inter2_r) * PROD_W'(iou_recip);
  end

  always_comb begin
    stat.busy    = v1_r | v2_r | v3_r;
    stat.hit_vld = v3_r;
    if (uni3_r < 0) begin
      stat.hit = 1'b0;
    end else if (uni3_r == 0) begin
      stat.hit = v3_r & (inter3_r != '0);
    end else begin
      stat.hit = v3_r & (prod3_r > PROD_W'(uni3_r[UNI_W-2:0]));
    end
  end

endmodule

/* hdl/greedy_iou_box_suppressor.sv */
// channel   dir  handshake      payload
// in_box    in   valid/ready    box_x, box_y, box_w, box_h, frame_start
// out_res   out  valid/ready    verdict, kept_total
// cfg       in   cfg_we only    cfg_idx, cfg_wdata
//
// an item makes three passes through one shared multiplier, then, unless the table
// is empty, streams one kept box per cycle through the overlap pipeline and waits
// for that pipeline to drain.
// synchronous active-low reset empties the table and loads register defaults.
// in_box.ready is high only when idle; a finished result waits in the output
// register and the next item is taken meanwhile.
module greedy_iou_box_suppressor (
  input  logic                             clk,
  input  logic                             rst_n,
  gnms_box_if.sink                         in_box,
  gnms_res_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [gnms_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [gnms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gnms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_WIDE,
    ST_TALL,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [RECIP_W-1:0] iou_recip_r;
  logic [RATIO_W-1:0] aspect_max_r, aspect_min_r;
  logic [CNT_W-1:0]   kept_cnt_r, scan_r;
  logic               rd_vld_r, sup_r;
  logic               out_valid_r;
  logic [1:0]         out_verdict_r;
  logic [CNT_W-1:0]   out_total_r;

  gnms_entry_t        box_r, rd_q_r;
  logic [AREA_W-1:0]  wide_lim_r, tall_lim_r;
  gnms_entry_t        kept_mem [MAX_KEPT];

  logic [SIZE_W-1:0]  mul_a, mul_b;
  logic [AREA_W-1:0]  mul_p;
  logic               in_acc, slot_free, aspect_bad, mem_we;
  logic [1:0]         verdict_nxt;
  gnms_ovl_stat_t     ovl_stat;

  assign in_acc    = in_box.valid & in_box.ready;
  assign slot_free = !out_valid_r || out_res.ready;

  assign in_box.ready       = (state_r == ST_IDLE);
  assign out_res.valid      = out_valid_r;
  assign out_res.verdict    = out_verdict_r;
  assign out_res.kept_total = out_total_r;

  // shared multiplier
  always_comb begin
    unique case (state_r)
      ST_WIDE: begin
        mul_a = SIZE_W'(aspect_max_r) + SIZE_W'(1);
        mul_b = box_r.h;
      end
      ST_TALL: begin
        mul_a = SIZE_W'(aspect_min_r);
        mul_b = box_r.w;
      end
      default: begin
        mul_a = box_r.w;
        mul_b = box_r.h;
      end
    endcase
  end
  assign mul_p = AREA_W'(mul_a) * AREA_W'(mul_b);

  // floor(w/h) > max  <=>  w >= (max+1)*h ; floor(h/w) < min  <=>  h < min*w
  assign aspect_bad = (box_r.h == '0) || (AREA_W'(box_r.w) >= wide_lim_r) ||
                      ((box_r.w != '0) && (AREA_W'(box_r.h) < tall_lim_r));

  always_comb begin
    if (sup_r) begin
      verdict_nxt = VERDICT_SUPPRESSED;
    end else if (aspect_bad) begin
      verdict_nxt = VERDICT_ASPECT;
    end else if (kept_cnt_r >= CNT_W'(MAX_KEPT)) begin
      verdict_nxt = VERDICT_FULL;
    end else begin
      verdict_nxt = VERDICT_KEPT;
    end
  end

  assign mem_we = (state_r == ST_FIN) && slot_free && (verdict_nxt == VERDICT_KEPT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      iou_recip_r   <= IOU_RECIP_RST;
      aspect_max_r  <= ASPECT_MAX_RST;
      aspect_min_r  <= ASPECT_MIN_RST;
      kept_cnt_r    <= '0;
      scan_r        <= '0;
      rd_vld_r      <= 1'b0;
      sup_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_verdict_r <= VERDICT_KEPT;
      out_total_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_IOU_RECIP:  iou_recip_r  <= cfg_wdata;
          CFG_ASPECT_MAX: aspect_max_r <= cfg_wdata[RATIO_W-1:0];
          CFG_ASPECT_MIN: aspect_min_r <= cfg_wdata[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_res.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= (state_r == ST_SCAN);
      if (ovl_stat.hit_vld && ovl_stat.hit) begin
        sup_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_box.frame_start) begin
              kept_cnt_r <= '0;
            end
            scan_r  <= '0;
            sup_r   <= 1'b0;
            state_r <= ST_AREA;
          end
        end
        ST_AREA: state_r <= ST_WIDE;
        ST_WIDE: state_r <= ST_TALL;
        ST_TALL: state_r <= (kept_cnt_r == '0) ? ST_FIN : ST_SCAN;
        ST_SCAN: begin
          scan_r <= scan_r + CNT_W'(1);
          if (scan_r + CNT_W'(1) == kept_cnt_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_r && !ovl_stat.busy) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= verdict_nxt;
            if (verdict_nxt == VERDICT_KEPT) begin
              kept_cnt_r  <= kept_cnt_r + CNT_W'(1);
              out_total_r <= kept_cnt_r + CNT_W'(1);
            end else begin
              out_total_r <= kept_cnt_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      box_r.x <= in_box.box_x;
      box_r.y <= in_box.box_y;
      box_r.w <= in_box.box_w;
      box_r.h <= in_box.box_h;
    end
    if (state_r == ST_AREA) begin
      box_r.area <= mul_p;
    end
    if (state_r == ST_WIDE) begin
      wide_lim_r <= mul_p;
    end
    if (state_r == ST_TALL) begin
      tall_lim_r <= mul_p;
    end
  end

  // kept table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      kept_mem[kept_cnt_r[IDX_W-1:0]] <= box_r;
    end
    rd_q_r <= kept_mem[scan_r[IDX_W-1:0]];
  end

  gnms_overlap u_overlap (
    .clk       (clk),
    .rst_n     (rst_n),
    .iou_recip (iou_recip_r),
    .cur_box   (box_r),
    .kept_vld  (rd_vld_r),
    .kept_box  (rd_q_r),
    .stat      (ovl_stat)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= CNT_W'(MAX_KEPT))
    else $error("kept count above table size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (kept_cnt_r < CNT_W'(MAX_KEPT)))
    else $error("table written while full");

  a_hit_window: assert property (@(posedge clk) disable iff (!rst_n)
    ovl_stat.hit_vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("overlap result outside scan");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_AREA))
    else $error("item accepted without starting");
`endif

endmodule

/* tb/testbench.sv */
module testbench;
  import gnms_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_LEN = 400;
  localparam int DRAIN_CYCLES = MAX_KEPT + 16;
  localparam int ITEMS_PER_PHASE = 170;
  localparam longint QUOT_BY_ZERO = 4095;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              fs;
  } box_item_t;

  typedef struct {
    logic [1:0]       verdict;
    logic [CNT_W-1:0] kept_total;
  } verdict_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gnms_box_if in_box();
  gnms_res_if out_res();

  greedy_iou_box_suppressor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_box    (in_box),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  box_item_t pending_boxes[$];
  verdict_t  expected_verdicts[$];

  box_item_t          kept_tbl[MAX_KEPT];
  int                 kept_cnt = 0;
  logic [RECIP_W-1:0] cur_recip = IOU_RECIP_RST;
  logic [RATIO_W-1:0] cur_amax = ASPECT_MAX_RST;
  logic [RATIO_W-1:0] cur_amin = ASPECT_MIN_RST;

  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_on = 0;
  int        hold_cycles = 0;
  box_item_t offered;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_errors = 0;
  int        n_settings = 1;
  int        cycle_cnt = 0;
  int        verdict_seen[4] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint lesser(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint greater(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint ratio_floor(longint n, longint d);
    return (d == 0) ? QUOT_BY_ZERO : n / d;
  endfunction

  function automatic bit too_close(box_item_t b, box_item_t k);
    longint bx, by, bw, bh, kx, ky, kw, kh;
    longint iw, ih, inter, uni, recip;
    bx = longint'(b.x); by = longint'(b.y); bw = longint'(b.w); bh = longint'(b.h);
    kx = longint'(k.x); ky = longint'(k.y); kw = longint'(k.w); kh = longint'(k.h);
    recip = longint'(cur_recip);
    iw = greater(0, lesser(bx + bw, kx + kw) - greater(bx, kx) + 1);
    ih = greater(0, lesser(by + bh, ky + kh) - greater(by, ky) + 1);
    inter = iw * ih;
    uni = bw * bh + kw * kh - inter;
    if (uni < 0) return 1'b0;
    if (uni == 0) return inter > 0;
    return inter * recip > uni;
  endfunction

  function automatic verdict_t judge_box(box_item_t b);
    verdict_t r;
    bit       hit;
    longint   bw, bh, amax, amin;
    hit = 1'b0;
    bw = longint'(b.w);
    bh = longint'(b.h);
    amax = longint'(cur_amax);
    amin = longint'(cur_amin);
    if (b.fs) kept_cnt = 0;
    for (int i = 0; i < kept_cnt && !hit; i++) hit = too_close(b, kept_tbl[i]);
    if (hit) begin
      r.verdict = VERDICT_SUPPRESSED;
    end else if (ratio_floor(bw, bh) > amax || ratio_floor(bh, bw) < amin) begin
      r.verdict = VERDICT_ASPECT;
    end else if (kept_cnt >= MAX_KEPT) begin
      r.verdict = VERDICT_FULL;
    end else begin
      kept_tbl[kept_cnt] = b;
      kept_cnt++;
      r.verdict = VERDICT_KEPT;
    end
    r.kept_total = CNT_W'(kept_cnt);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_box.valid <= 1'b0;
    end else begin
      if (in_box.valid && in_box.ready) begin
        expected_verdicts.insert(expected_verdicts.size(), judge_box(offered));
        n_sent++;
      end
      if (!in_box.valid || in_box.ready) begin
        if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_boxes.pop_front();
          in_box.valid       <= 1'b1;
          in_box.box_x       <= offered.x;
          in_box.box_y       <= offered.y;
          in_box.box_w       <= offered.w;
          in_box.box_h       <= offered.h;
          in_box.frame_start <= offered.fs;
        end else begin
          in_box.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold
  always @(posedge clk) begin
    if (rst_n && hold_on && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        verdict_seen[out_res.verdict]++;
        if (expected_verdicts.size() == 0) begin
          $error("result with no box outstanding: verdict %0d kept_total %0d",
                 out_res.verdict, out_res.kept_total);
          n_errors++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          n_checked++;
          if (out_res.verdict !== exp_v.verdict) begin
            $error("verdict: expected %0d, actual %0d", exp_v.verdict, out_res.verdict);
            n_errors++;
          end
          if (out_res.kept_total !== exp_v.kept_total) begin
            $error("kept_total: expected %0d, actual %0d",
                   exp_v.kept_total, out_res.kept_total);
            n_errors++;
          end
        end
      end
      if (hold_on && hold_cycles < HOLD_LEN) begin
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic add_box(int x, int y, int w, int h, bit fs);
    box_item_t b;
    b.x = POS_W'(x);
    b.y = POS_W'(y);
    b.w = SIZE_W'(w);
    b.h = SIZE_W'(h);
    b.fs = fs;
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    while (pending_boxes.size() != 0 || in_box.valid || expected_verdicts.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RECIP_W-1:0] val);
    @(posedge clk);
    cfg_we  <= 1'b1;
    cfg_idx <= idx;
    case (idx)
      CFG_IOU_RECIP: begin
        cfg_wdata <= val;
        cur_recip = val;
      end
      CFG_ASPECT_MAX: begin
        cfg_wdata <= {8'($urandom), val[RATIO_W-1:0]};
        cur_amax = val[RATIO_W-1:0];
      end
      CFG_ASPECT_MIN: begin
        cfg_wdata <= {8'($urandom), val[RATIO_W-1:0]};
        cur_amin = val[RATIO_W-1:0];
      end
      default: begin
        cfg_wdata <= 16'($urandom);
      end
    endcase
  endtask

  task automatic set_phase(int recip, int amax, int amin, int send_pct, int recv_pct);
    wait_drained();
    write_reg(CFG_IOU_RECIP, RECIP_W'(recip));
    write_reg(CFG_ASPECT_MAX, RECIP_W'(amax));
    write_reg(CFG_ASPECT_MIN, RECIP_W'(amin));
    write_reg(CFG_UNUSED, RECIP_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    n_settings++;
  endtask

  task automatic queue_random(int n_items);
    box_item_t recent[$];
    box_item_t b;
    int        made, kind, len, pick, w;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(9);
      if (kind == 9) begin
        // spaced grid, more boxes than the table holds
        for (int row = 0; row < 8; row++) begin
          for (int col = 0; col < 9; col++) begin
            w = $urandom_range(8, 100);
            add_box(col * 220 + $urandom_range(50), row * 250 + $urandom_range(50),
                    w, w + $urandom_range(60), row == 0 && col == 0);
          end
        end
        made += 72;
      end else begin
        len = $urandom_range(2, 40);
        recent.delete();
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(9);
          if (pick < 6) begin
            b.x = POS_W'($urandom);
            b.y = POS_W'($urandom);
            b.w = SIZE_W'($urandom_range(1, 64));
            b.h = SIZE_W'(b.w * $urandom_range(1, 3) + $urandom_range(7));
          end else if (pick < 8 && recent.size() != 0) begin
            b = recent[$urandom_range(recent.size() - 1)];
            b.x = POS_W'(b.x + $urandom_range(3));
            b.y = POS_W'(b.y + $urandom_range(3));
          end else begin
            b.x = POS_W'($urandom);
            b.y = POS_W'($urandom);
            b.w = SIZE_W'($urandom);
            b.h = SIZE_W'($urandom);
            if ($urandom_range(3) == 0) b.w = '0;
            if ($urandom_range(3) == 0) b.h = '0;
          end
          // kind 7 continues the previous table without forcing a frame start
          b.fs = (i == 0 && kind != 7) || $urandom_range(31) == 0;
          pending_boxes.insert(pending_boxes.size(), b);
          recent.insert(recent.size(), b);
          made++;
        end
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_box.valid       = 1'b0;
    in_box.box_x       = '0;
    in_box.box_y       = '0;
    in_box.box_w       = '0;
    in_box.box_h       = '0;
    in_box.frame_start = 1'b0;
    out_res.ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    add_box(0, 0, 100, 100, 1);
    add_box(100, 100, 1, 1, 0);           // overlap exactly at threshold
    add_box(0, 0, 100, 100, 0);
    add_box(500, 0, 600, 100, 0);         // too wide
    add_box(500, 0, 200, 100, 0);         // height ratio below min
    add_box(500, 500, 10, 0, 0);          // zero height
    add_box(800, 800, 0, 10, 0);          // zero width
    add_box(799, 810, 1, 1, 0);           // zero union with overlap
    add_box(800, 805, 0, 0, 0);           // negative union
    add_box(2047, 2047, 4095, 4095, 0);
    add_box(2047, 2047, 2048, 2048, 0);
    add_box(0, 2047, 4095, 1, 0);
    add_box(1024, 1024, 2048, 2048, 0);
    add_box(10, 10, 100, 1, 1);
    add_box(1000, 1000, 3, 3, 0);
    add_box(1000, 1000, 3, 3, 0);
    add_box(0, 0, 1, 5, 0);
    add_box(1365, 682, 1365, 2730, 0);
    add_box(682, 1365, 2730, 2730, 0);

    set_phase(IOU_RECIP_RST, ASPECT_MAX_RST, ASPECT_MIN_RST, 0, 0);
    queue_random(ITEMS_PER_PHASE);
    set_phase(1, 255, 0, 59, 0);
    queue_random(ITEMS_PER_PHASE);
    set_phase(65535, 0, 0, 0, 59);
    queue_random(ITEMS_PER_PHASE);
    set_phase(0, 2, 0, 29, 29);
    queue_random(ITEMS_PER_PHASE);
    set_phase(2, 255, 255, 0, 0);
    hold_on = 1'b1;
    queue_random(ITEMS_PER_PHASE);
    set_phase(100, 5, 1, 29, 29);
    queue_random(ITEMS_PER_PHASE);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d boxes over %0d register settings, %0d results checked, %0d errors",
             n_sent, n_settings, n_checked, n_errors);
    $display("verdicts seen: kept %0d, overlap %0d, aspect %0d, table full %0d",
             verdict_seen[VERDICT_KEPT], verdict_seen[VERDICT_SUPPRESSED],
             verdict_seen[VERDICT_ASPECT], verdict_seen[VERDICT_FULL]);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
